/* design/arpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

   typedef struct packed {
      logic        cmd;
      logic [15:0] opcode;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [47:0] target_mac;
      logic [31:0] target_ip;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [47:0] resolved_mac;
      logic        send_packet;
      logic [1:0]  pkt_opcode;
      logic [47:0] pkt_sender_mac;
      logic [31:0] pkt_sender_ip;
      logic [47:0] pkt_target_mac;
      logic [31:0] pkt_target_ip;
      logic [47:0] pkt_dest_mac;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   localparam logic        CMD_MESSAGE = 1'b0;
   localparam logic        CMD_RESOLVE = 1'b1;

   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

   localparam logic [1:0]  PKT_OP_REQUEST = 2'd1;
   localparam logic [1:0]  PKT_OP_REPLY   = 2'd2;

   localparam logic [1:0]  STATUS_OK         = 2'd0;
   localparam logic [1:0]  STATUS_BAD_OPCODE = 2'd1;
   localparam logic [1:0]  STATUS_FULL       = 2'd2;
   localparam logic [1:0]  STATUS_MISS       = 2'd3;

   localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

/* design/arp_cache_responder.sv */
`timescale 1ns / 1ps
`default_nettype none

// ARP cache and responder. Takes one beat at a time on req_: an incoming ARP
// message (cmd 0) or a resolve query (cmd 1), and returns exactly one result
// beat on rsp_. The IPv4 to MAC table sits in a single-port-read RAM and is
// walked one entry per cycle from entry 0 up to the fill count. The walk stops
// early on a hit, and an empty table is a miss without any read. An item then
// passes through a hand-over state before the block returns to idle, so the
// next item is accepted only once this one is through. An ARP reply that also
// teaches the target pair walks the table twice, the second time over up to
// n + 1 entries, n being the fill count at the start. An invalid opcode skips
// the walk and goes straight to hand-over. req_ready is high only while no item
// is in progress; the result register lets one finished beat wait on rsp_ready
// while the next item is accepted, and a later item holds in its hand-over
// state until that beat has gone. own_mac is written through csr_, which is
// always ready, and must only be changed while the block is idle. The table
// needs no clearing after reset: the fill count alone marks which entries are
// live.
module arp_cache_responder #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire arpc_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      arpc_pkg::rsp_type rsp_data,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [47:0]       csr_data
);

   import arpc_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  issue_idx_ff, issue_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   req_type           item_ff, item_in;
   logic              phase_ff, phase_in;
   logic [31:0]       key_ip_ff, key_ip_in;
   logic [47:0]       key_mac_ff, key_mac_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [47:0]       own_mac_ff, own_mac_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   entry_type         ram_wdata;
   logic [$bits(entry_type)-1:0] ram_rdata;
   entry_type         rd_entry;

   logic req_accept;
   logic bad_opcode;
   logic issue;
   logic hit;
   logic miss;
   logic search_done;
   logic is_resolve;
   logic table_full;
   logic more_learn;
   logic load_rsp;

   assign rd_entry  = entry_type'(ram_rdata);
   assign ram_wdata = '{ip: key_ip_ff, mac: key_mac_ff};

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign bad_opcode = (req_data.cmd == CMD_MESSAGE) &&
                       (req_data.opcode != ARP_OP_REQUEST) &&
                       (req_data.opcode != ARP_OP_REPLY);

   // Reads are issued one per cycle; the compare sees the entry issued in the
   // cycle before, so the walk still stops at the first matching entry.
   assign hit         = rd_pend_ff && (rd_entry.ip == key_ip_ff);
   assign miss        = !rd_pend_ff && (issue_idx_ff == count_ff);
   assign issue       = (state_ff == ST_SEARCH) && (issue_idx_ff != count_ff) && !hit;
   assign search_done = (state_ff == ST_SEARCH) && (hit || miss);

   assign is_resolve = (item_ff.cmd == CMD_RESOLVE);
   assign table_full = miss && (count_ff == CNT_W'(TABLE_DEPTH));
   assign more_learn = !is_resolve && !table_full && (item_ff.opcode == ARP_OP_REPLY) &&
                       !phase_ff && (item_ff.target_mac != BCAST_MAC);

   assign csr_ready  = 1'b1;
   assign own_mac_in = (csr_valid && csr_ready) ? csr_data : own_mac_ff;

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load_rsp;
   assign rsp_in       = load_rsp ? res_ff : rsp_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = bad_opcode ? ST_DONE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (search_done && !more_learn) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control.
   always_comb begin
      count_in     = count_ff;
      issue_idx_in = issue_idx_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      item_in      = item_ff;
      phase_in     = phase_ff;
      key_ip_in    = key_ip_ff;
      key_mac_in   = key_mac_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = rd_idx_ff;
      ram_raddr    = issue_idx_ff[ADDR_W-1:0];
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in      = req_data;
               phase_in     = 1'b0;
               key_ip_in    = (req_data.cmd == CMD_RESOLVE) ? req_data.target_ip
                                                            : req_data.sender_ip;
               key_mac_in   = req_data.sender_mac;
               issue_idx_in = '0;
               res_in       = '0;
               if (bad_opcode) begin
                  res_in.status = STATUS_BAD_OPCODE;
               end
            end
         end
         ST_SEARCH: begin
            rd_pend_in = issue;
            rd_idx_in  = issue_idx_ff[ADDR_W-1:0];
            if (issue) begin
               issue_idx_in = issue_idx_ff + 1'b1;
            end
            if (search_done) begin
               if (is_resolve) begin
                  if (hit) begin
                     res_in.found        = 1'b1;
                     res_in.resolved_mac = rd_entry.mac;
                  end else begin
                     res_in.status         = STATUS_MISS;
                     res_in.send_packet    = 1'b1;
                     res_in.pkt_opcode     = PKT_OP_REQUEST;
                     res_in.pkt_sender_mac = own_mac_ff;
                     res_in.pkt_sender_ip  = item_ff.sender_ip;
                     res_in.pkt_target_mac = BCAST_MAC;
                     res_in.pkt_target_ip  = item_ff.target_ip;
                     res_in.pkt_dest_mac   = BCAST_MAC;
                  end
               end else if (table_full) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  ram_we = 1'b1;
                  if (!hit) begin
                     ram_waddr = count_ff[ADDR_W-1:0];
                     count_in  = count_ff + 1'b1;
                  end
                  if (item_ff.opcode == ARP_OP_REQUEST) begin
                     res_in.send_packet    = 1'b1;
                     res_in.pkt_opcode     = PKT_OP_REPLY;
                     res_in.pkt_sender_mac = own_mac_ff;
                     res_in.pkt_sender_ip  = item_ff.target_ip;
                     res_in.pkt_target_mac = item_ff.sender_mac;
                     res_in.pkt_target_ip  = item_ff.sender_ip;
                     res_in.pkt_dest_mac   = item_ff.sender_mac;
                  end else if (more_learn) begin
                     // Second walk for the target pair; it sees the entry
                     // just written, as the RAM write lands before the read.
                     phase_in     = 1'b1;
                     key_ip_in    = item_ff.target_ip;
                     key_mac_in   = item_ff.target_mac;
                     issue_idx_in = '0;
                     rd_pend_in   = 1'b0;
                  end
               end
            end
         end
         ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_mac_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         own_mac_ff   <= own_mac_in;
      end
      issue_idx_ff <= issue_idx_in;
      rd_idx_ff    <= rd_idx_in;
      item_ff      <= item_in;
      phase_ff     <= phase_in;
      key_ip_ff    <= key_ip_in;
      key_mac_ff   <= key_mac_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   arpc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire

/* design/arpc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module arpc_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* design/arpc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module arpc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire arpc_pkg::rsp_type rsp_data
);

   import arpc_pkg::*;

   // A result beat that is held back must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Only one item is in progress at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item was in progress");

   // With no packet to send, the packet opcode, destination MAC and target IP read as zero.
   a_no_pkt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_packet |->
         rsp_data.pkt_opcode == 2'd0 && rsp_data.pkt_dest_mac == 48'd0 &&
         rsp_data.pkt_target_ip == 32'd0)
      else $error("packet fields set without a packet");

   // A hit reports success and sends nothing.
   a_hit_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |->
         rsp_data.status == STATUS_OK && !rsp_data.send_packet)
      else $error("resolve hit with bad status or packet");

   // A miss always goes out as a broadcast request; a packet sent otherwise is
   // a reply to the requester.
   a_pkt_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_packet |->
         (rsp_data.status == STATUS_MISS && rsp_data.pkt_opcode == PKT_OP_REQUEST &&
          rsp_data.pkt_dest_mac == BCAST_MAC) ||
         (rsp_data.status == STATUS_OK && rsp_data.pkt_opcode == PKT_OP_REPLY &&
          rsp_data.pkt_dest_mac == rsp_data.pkt_target_mac))
      else $error("emitted packet inconsistent with status");

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (.*);

`default_nettype wire
